@@ hdl/hfd_pkg.sv @@
// Shared types and constants for the humidity sensor frame decoder.
// Standalone package; imported by every module of the decoder.
package hfd_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TEMP_CRC  = 2'd1,
		ST_HUMID_CRC = 2'd2
	} status_t;

	// Completed frame as handed from the frame tracker to the converter.
	typedef struct packed {
		logic        temp_bad;
		logic        humid_bad;
		logic [15:0] temp_word;
		logic [15:0] humid_word;
	} frame_t;

endpackage

@@ hdl/hfd_frame_track.sv @@
// Byte position tracking, CRC-8 checking and word capture for the decoder.
// Depends on hfd_pkg; registers one completed frame in stage 1.
module hfd_frame_track (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	input  logic          frame_start,
	input  logic [7:0]    crc_poly,
	input  logic          take_s1,
	output logic          frame_valid_s1,
	output hfd_pkg::frame_t frame_s1
);
	import hfd_pkg::*;

	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] humid_word_q;
	logic        temp_bad_q;
	logic [2:0]  pos;
	logic [7:0]  crc_from_init;
	logic [7:0]  crc_from_run;

	// One byte of CRC-8, MSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
	                                         input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ poly;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

	always_comb begin
		pos = frame_start ? POS_TEMP_HI : pos_q;
		if (pos > POS_HUM_CRC) begin
			pos = POS_TEMP_HI;
		end
		crc_from_init = crc8_byte(CRC_INIT, rx_byte, crc_poly);
		crc_from_run  = crc8_byte(crc_q, rx_byte, crc_poly);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_TEMP_HI;
			crc_q        <= CRC_INIT;
			temp_word_q  <= '0;
			humid_word_q <= '0;
			temp_bad_q   <= 1'b0;
		end else if (accept) begin
			pos_q <= (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
			case (pos)
				POS_TEMP_HI: begin
					temp_word_q <= {rx_byte, 8'h00};
					crc_q       <= crc_from_init;
				end
				POS_TEMP_LO: begin
					temp_word_q <= {temp_word_q[15:8], rx_byte};
					crc_q       <= crc_from_run;
				end
				POS_TEMP_CRC: begin
					temp_bad_q <= (crc_q != rx_byte);
				end
				POS_HUM_HI: begin
					humid_word_q <= {rx_byte, 8'h00};
					crc_q        <= crc_from_init;
				end
				POS_HUM_LO: begin
					humid_word_q <= {humid_word_q[15:8], rx_byte};
					crc_q        <= crc_from_run;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (accept && pos == POS_HUM_CRC) begin
			frame_valid_s1 <= 1'b1;
		end else if (take_s1) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos == POS_HUM_CRC) begin
			frame_s1.temp_bad   <= temp_bad_q;
			frame_s1.humid_bad  <= (crc_q != rx_byte);
			frame_s1.temp_word  <= temp_word_q;
			frame_s1.humid_word <= humid_word_q;
		end
	end

endmodule

@@ hdl/hfd_convert.sv @@
// Status selection and fixed-point conversion of a completed frame.
// Depends on hfd_pkg; holds the result register of the decoder.
module hfd_convert (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  hfd_pkg::frame_t        frame_s1,
	input  logic signed [11:0]     temp_offset,
	input  logic                   out_ready,
	output logic                   out_valid,
	output hfd_pkg::status_t       status,
	output logic signed [14:0]     temperature_centi,
	output logic [13:0]            humidity_centi
);
	import hfd_pkg::*;

	localparam logic [14:0] TEMP_SCALE = 15'd17500;
	localparam logic [13:0] HUM_SCALE  = 14'd10000;
	localparam logic signed [15:0] TEMP_BIAS = 16'sd4500;
	localparam logic signed [15:0] TEMP_MIN  = -16'sd6500;
	localparam logic signed [15:0] TEMP_MAX  = 16'sd15000;

	logic [30:0]        temp_prod;
	logic [29:0]        hum_prod;
	logic signed [15:0] temp_raw;
	logic signed [14:0] temp_sat;
	status_t            status_d;
	logic               out_valid_q;
	status_t            status_q;
	logic signed [14:0] temp_q;
	logic [13:0]        hum_q;

	always_comb begin
		temp_prod = {16'd0, TEMP_SCALE} * {15'd0, frame_s1.temp_word};
		hum_prod  = {16'd0, HUM_SCALE} * {14'd0, frame_s1.humid_word};
		temp_raw  = $signed({1'b0, temp_prod[30:16]}) - TEMP_BIAS
		            - {{4{temp_offset[11]}}, temp_offset};
		if (temp_raw < TEMP_MIN) begin
			temp_sat = TEMP_MIN[14:0];
		end else if (temp_raw > TEMP_MAX) begin
			temp_sat = TEMP_MAX[14:0];
		end else begin
			temp_sat = temp_raw[14:0];
		end
		if (frame_s1.temp_bad) begin
			status_d = ST_TEMP_CRC;
		end else if (frame_s1.humid_bad) begin
			status_d = ST_HUMID_CRC;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= status_d;
			// Values are reported as zero whenever either checksum fails.
			temp_q   <= (status_d == ST_OK) ? temp_sat : '0;
			hum_q    <= (status_d == ST_OK) ? hum_prod[29:16] : '0;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign temperature_centi = temp_q;
	assign humidity_centi    = hum_q;

endmodule

@@ hdl/humidity_sensor_frame_decoder_unit.sv @@
// Top level of the humidity sensor frame decoder: ports, configuration
// registers and stage handshakes. Depends on hfd_pkg, hfd_frame_track, hfd_convert.
//
//  Channel | Direction | Signals                               | Carries
//  --------+-----------+---------------------------------------+----------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser     | one frame byte per transaction
//  m_*     | out       | m_tvalid m_tready m_tdata             | one decoded result per frame
//  cfg_*   | in        | cfg_valid cfg_ready cfg_index cfg_data| register writes
//
// One byte is accepted per cycle while stage 1 is free or moving on. The sixth byte's
// transaction edge loads stage 1 with both checksum verdicts and both words. When stage 1
// moves on, the frame passes through the conversion multipliers into the result register,
// which drives m_tdata. Reset leaves the byte count at the first byte, the running CRC at
// 0xFF and the polynomial at 0x31. A stalled result holds the result register and then
// stage 1; once both are full, s_tready drops for every byte until the result is taken.
module humidity_sensor_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Byte input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	// Result output.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [1:0] status, [16:2] temperature_centi,
	                               // [30:17] humidity_centi, [31] zero
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import hfd_pkg::*;

	localparam logic [1:0] CFG_CRC_POLY    = 2'd0;
	localparam logic [1:0] CFG_TEMP_OFFSET = 2'd1;

	logic               accept;
	logic               take_s1;
	logic               frame_valid_s1;
	frame_t             frame_s1;
	logic [7:0]         crc_poly_q;
	logic signed [11:0] temp_offset_q;
	status_t            status;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;

	// Configuration is taken in any cycle; indexes beyond the list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q    <= 8'h31;
			temp_offset_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CRC_POLY:    crc_poly_q    <= cfg_data[7:0];
				CFG_TEMP_OFFSET: temp_offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage 1 moves on when the result register is empty or being emptied.
	// A byte is taken whenever stage 1 is free or moving on in this cycle.
	assign take_s1  = frame_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !frame_valid_s1 || take_s1;
	assign accept   = s_tvalid && s_tready;

	hfd_frame_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.rx_byte        (s_tdata),
		.frame_start    (s_tuser),
		.crc_poly       (crc_poly_q),
		.take_s1        (take_s1),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	hfd_convert u_convert (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (take_s1),
		.frame_s1          (frame_s1),
		.temp_offset       (temp_offset_q),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.status            (status),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi)
	);

	assign m_tdata = {1'b0, humidity_centi, temperature_centi, status};

endmodule

@@ tb/humidity_sensor_frame_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for humidity_sensor_frame_decoder_unit: frame bytes in, decoded
// results out, checked against a cycle-free decoder prediction. Depends on hfd_pkg and the RTL.
module humidity_sensor_frame_decoder_unit_tb;
	import hfd_pkg::*;

	localparam logic [1:0] REG_CRC_POLY    = 2'd0;
	localparam logic [1:0] REG_TEMP_OFFSET = 2'd1;
	localparam int FRAME_LEN      = 6;
	localparam int TEMP_FLOOR     = -6500;
	localparam int TEMP_CEIL      = 15000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int STALL_LIMIT    = 4000;
	localparam int PHASE_BYTES    = 115;

	typedef struct {
		logic [7:0] rx;
		logic       fs;
	} frame_byte_t;

	typedef struct {
		status_t     status;
		logic [14:0] temp;
		logic [13:0] humid;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	// Pending bytes for the driver and readings still owed by the block.
	frame_byte_t byte_q[$];
	reading_t    reading_q[$];

	// Idle percentages of the sender and the receiver for the current phase.
	int send_idle_pct = 25;
	int recv_idle_pct = 82;
	int mismatch_cnt = 0;
	int quiet_cycles = 0;

	// Decoder copy: configuration and frame state, as they stand after reset.
	logic [7:0]  poly_cfg = 8'h31;
	int          offset_cfg = 0;
	logic [2:0]  byte_pos = '0;
	logic [7:0]  run_crc = CRC_INIT;
	logic [15:0] temp_word = '0;
	logic [15:0] humid_word = '0;
	logic        temp_bad = 1'b0;

	humidity_sensor_frame_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// CRC-8, MSB first, one byte.
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data,
			input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ poly) : (v << 1);
		end
		return v;
	endfunction

	// Advances the decoder copy by one accepted byte and queues the reading that the
	// sixth byte of a frame produces. A frame start restarts the count mid-frame, and
	// without one the count simply wraps after the sixth byte.
	task automatic decode_byte(input logic [7:0] rx, input logic fs);
		reading_t    r;
		int unsigned scaled;
		int          t;
		logic        humid_bad;
		if (fs)
			byte_pos = '0;
		if (byte_pos >= FRAME_LEN)
			byte_pos = '0;
		case (byte_pos)
			3'd0: begin
				temp_word = {rx, 8'h00};
				run_crc = crc8_next(CRC_INIT, rx, poly_cfg);
			end
			3'd1: begin
				temp_word[7:0] = rx;
				run_crc = crc8_next(run_crc, rx, poly_cfg);
			end
			3'd2: begin
				temp_bad = (run_crc != rx);
			end
			3'd3: begin
				humid_word = {rx, 8'h00};
				run_crc = crc8_next(CRC_INIT, rx, poly_cfg);
			end
			3'd4: begin
				humid_word[7:0] = rx;
				run_crc = crc8_next(run_crc, rx, poly_cfg);
			end
			default: begin
			end
		endcase
		if (byte_pos < FRAME_LEN - 1) begin
			byte_pos = byte_pos + 3'd1;
		end else begin
			byte_pos = '0;
			humid_bad = (run_crc != rx);
			r.temp = '0;
			r.humid = '0;
			// The temperature check wins when both checksums are wrong, and any
			// checksum error zeroes both values.
			if (temp_bad) begin
				r.status = ST_TEMP_CRC;
			end else if (humid_bad) begin
				r.status = ST_HUMID_CRC;
			end else begin
				r.status = ST_OK;
				scaled = 17500 * temp_word;
				t = int'(scaled >> 16) - 4500 - offset_cfg;
				// Offsets beyond the nominal range can push the value past its limits.
				if (t < TEMP_FLOOR)
					t = TEMP_FLOOR;
				if (t > TEMP_CEIL)
					t = TEMP_CEIL;
				r.temp = t[14:0];
				scaled = 10000 * humid_word;
				r.humid = scaled[29:16];
			end
			reading_q.push_back(r);
		end
	endtask

	// Queues one whole frame; the corrupt flags spoil the matching checksum byte.
	task automatic push_frame(input logic [15:0] tw, input logic [15:0] hw,
			input logic temp_corrupt, input logic humid_corrupt, input logic fs);
		logic [7:0] tcrc;
		logic [7:0] hcrc;
		tcrc = crc8_next(crc8_next(CRC_INIT, tw[15:8], poly_cfg), tw[7:0], poly_cfg);
		hcrc = crc8_next(crc8_next(CRC_INIT, hw[15:8], poly_cfg), hw[7:0], poly_cfg);
		if (temp_corrupt)
			tcrc = tcrc ^ 8'($urandom_range(255, 1));
		if (humid_corrupt)
			hcrc = hcrc ^ 8'($urandom_range(255, 1));
		byte_q.push_back('{tw[15:8], fs});
		byte_q.push_back('{tw[7:0], 1'b0});
		byte_q.push_back('{tcrc, 1'b0});
		byte_q.push_back('{hw[15:8], 1'b0});
		byte_q.push_back('{hw[7:0], 1'b0});
		byte_q.push_back('{hcrc, 1'b0});
	endtask

	function automatic logic [15:0] pick_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 16'h0000;
		if (roll < 20)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Mostly well-formed frames with random content, the rest cut-off frames and noise.
	task automatic push_random_sequence();
		int roll;
		int crc_roll;
		int cut;
		roll = $urandom_range(99);
		if (roll < 72) begin
			crc_roll = $urandom_range(99);
			push_frame(pick_word(), pick_word(), crc_roll >= 80 && crc_roll < 90 || crc_roll >= 95,
				crc_roll >= 90, $urandom_range(99) < 85);
		end else if (roll < 86) begin
			cut = $urandom_range(FRAME_LEN - 1, 1);
			for (int i = 0; i < cut; i++)
				byte_q.push_back('{8'($urandom), i == 0});
		end else begin
			cut = $urandom_range(4, 1);
			for (int i = 0; i < cut; i++)
				byte_q.push_back('{8'($urandom), 1'($urandom_range(1))});
		end
	endtask

	// Waits until every queued byte has been taken and every reading has arrived, then
	// lets the last bytes that complete no frame work their way through.
	task automatic wait_drained();
		while (byte_q.size() != 0 || s_tvalid || reading_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready))
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_CRC_POLY)
			poly_cfg = value[7:0];
		else if (idx == REG_TEMP_OFFSET)
			offset_cfg = int'($signed(value));
	endtask

	task automatic run_phase(input logic [7:0] poly, input int offset);
		write_reg(REG_CRC_POLY, {4'h0, poly});
		write_reg(REG_TEMP_OFFSET, 12'(offset));
		while (byte_q.size() < PHASE_BYTES / 2)
			push_random_sequence();
		// The sender holds off here until the block has delivered everything it owes.
		while (byte_q.size() != 0 || s_tvalid || reading_q.size() != 0)
			@(posedge clk);
		while (byte_q.size() < PHASE_BYTES / 2)
			push_random_sequence();
		wait_drained();
	endtask

	// Byte driver: a byte stays on the bus until its transaction completes, and each
	// accepted byte is fed to the decoder copy at the edge that takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= byte_q[0].rx;
					s_tuser <= byte_q[0].fs;
					byte_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: each result transaction is matched against the oldest owed reading.
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reading_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("[%0t] result with nothing owed: tdata=%h", $realtime, m_tdata);
				end else begin
					want = reading_q.pop_front();
					if (m_tdata[1:0] !== want.status || m_tdata[16:2] !== want.temp ||
							m_tdata[30:17] !== want.humid || m_tdata[31] !== 1'b0) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("[%0t] mismatch: status %0d/%0d temp %0d/%0d humid %0d/%0d pad %b",
								$realtime, want.status, m_tdata[1:0], $signed(want.temp),
								$signed(m_tdata[16:2]), want.humid, m_tdata[30:17], m_tdata[31]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: a long run of cycles with no transaction on any channel means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("humidity_sensor_frame_decoder_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration. Extreme words with good checksums.
		push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		// Zero words, both checksums wrong, no frame start: the count wraps by itself.
		push_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0);
		// A frame cut short by a new frame start, which then has a bad temperature checksum.
		byte_q.push_back('{8'hFF, 1'b1});
		byte_q.push_back('{8'h00, 1'b0});
		byte_q.push_back('{8'hA5, 1'b0});
		push_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
		// Only the humidity checksum wrong.
		push_frame(16'h0001, 16'hFFFE, 1'b0, 1'b1, 1'b0);
		wait_drained();

		// Sender mostly busy, receiver mostly stalled. The first setting saturates low.
		run_phase(8'h31, 2047);
		run_phase(8'h07, -2048);
		// Roles swapped.
		@(posedge clk);
		send_idle_pct = 82;
		recv_idle_pct = 25;
		run_phase(8'h00, $urandom_range(4000) - 2000);
		run_phase(8'hFF, 0);
		// Full rate on both sides.
		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(8'($urandom), -2000);
		run_phase(8'h31, 2000);

		if (mismatch_cnt == 0 && reading_q.size() == 0)
			$display("humidity_sensor_frame_decoder_unit verification clean");
		else
			$display("humidity_sensor_frame_decoder_unit verification failed");
		$finish;
	end

endmodule
